/* sv/ncpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncpc_pkg
// Shared types and constants for the noncoprime prefix count block.
// ----------------------------------------------------------------------------
`default_nettype none

package ncpc_pkg;

  localparam int MAX_N_DEF = 131072;
  localparam int QUERY_W   = 18;
  localparam int COUNT_W   = 32;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_RD_I,
    ST_CHK,
    ST_RD_P,
    ST_MUL,
    ST_WR,
    ST_NEXT,
    ST_PRE_RD,
    ST_PRE_WR,
    ST_DONE
  } build_state_t;

endpackage

`default_nettype wire

/* sv/ncpc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncpc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ncpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/ncpc_builder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncpc_builder
// Table build sequencer: clears the factor map, runs a linear sieve that
// records the least prime factor and phi of every number from 2 to MAX_N, then
// sweeps the phi table once more turning it into the running sum of (m - phi(m)).
// ----------------------------------------------------------------------------
`default_nettype none

module ncpc_builder #(
  parameter int MAX_N = ncpc_pkg::MAX_N_DEF,
  parameter int VW    = $clog2(MAX_N + 1),
  parameter int PCAP  = MAX_N / 2 + 2,
  parameter int PW    = $clog2(PCAP)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // least prime factor map (0 = not yet marked)
  output logic                             lpf_we,
  output logic [VW-1:0]                    lpf_waddr,
  output logic [VW-1:0]                    lpf_wdata,
  output logic [VW-1:0]                    lpf_raddr,
  input  wire logic [VW-1:0]               lpf_rdata,
  // prime list
  output logic                             pr_we,
  output logic [PW-1:0]                    pr_waddr,
  output logic [VW-1:0]                    pr_wdata,
  output logic [PW-1:0]                    pr_raddr,
  input  wire logic [VW-1:0]               pr_rdata,
  // phi table, later the prefix table
  output logic                             tb_we,
  output logic [VW-1:0]                    tb_waddr,
  output logic [ncpc_pkg::COUNT_W-1:0]     tb_wdata,
  output logic [VW-1:0]                    tb_raddr,
  input  wire logic [ncpc_pkg::COUNT_W-1:0] tb_rdata,
  output logic                             ready
);

  localparam logic [VW-1:0] LAST = VW'(MAX_N);

  ncpc_pkg::build_state_t state, state_next;

  logic [VW-1:0]                 idx, idx_next;      // clear / sieve / prefix index
  logic [PW:0]                   cnt, cnt_next;      // primes listed
  logic [PW:0]                   pj, pj_next;        // prime list cursor
  logic [VW-1:0]                 lpf_i, lpf_i_next;
  logic [VW-1:0]                 phi_i, phi_i_next;
  logic [VW-1:0]                 p_reg, p_reg_next;
  logic [2*VW-1:0]               prod, prod_next;
  logic [2*VW-1:0]               fprod, fprod_next;
  logic                          last, last_next;
  logic [ncpc_pkg::COUNT_W-1:0]  acc, acc_next;
  logic [ncpc_pkg::COUNT_W-1:0]  term;
  logic [VW-1:0]                 fac;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncpc_pkg::ST_CLEAR;
      idx   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      cnt   <= cnt_next;
    end
    pj    <= pj_next;
    lpf_i <= lpf_i_next;
    phi_i <= phi_i_next;
    p_reg <= p_reg_next;
    prod  <= prod_next;
    fprod <= fprod_next;
    last  <= last_next;
    acc   <= acc_next;
  end

  // factor for phi(i*p): p when p divides i (p is i's least factor), else p-1
  assign fac  = (pr_rdata == lpf_i) ? pr_rdata : pr_rdata - VW'(1);
  assign term = (idx >= VW'(2)) ?
                (ncpc_pkg::COUNT_W'(idx) - ncpc_pkg::COUNT_W'(tb_rdata[VW-1:0])) : '0;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cnt_next   = cnt;
    pj_next    = pj;
    lpf_i_next = lpf_i;
    phi_i_next = phi_i;
    p_reg_next = p_reg;
    prod_next  = prod;
    fprod_next = fprod;
    last_next  = last;
    acc_next   = acc;
    lpf_we     = 1'b0;
    lpf_waddr  = idx;
    lpf_wdata  = '0;
    lpf_raddr  = idx;
    pr_we      = 1'b0;
    pr_waddr   = cnt[PW-1:0];
    pr_wdata   = idx;
    pr_raddr   = pj[PW-1:0];
    tb_we      = 1'b0;
    tb_waddr   = idx;
    tb_wdata   = '0;
    tb_raddr   = idx;
    ready      = 1'b0;
    unique case (state)
      ncpc_pkg::ST_CLEAR: begin
        lpf_we = 1'b1;
        if (idx == LAST) begin
          idx_next   = VW'(2);
          state_next = ncpc_pkg::ST_RD_I;
        end else begin
          idx_next = idx + VW'(1);
        end
      end
      ncpc_pkg::ST_RD_I: begin
        state_next = ncpc_pkg::ST_CHK;
      end
      ncpc_pkg::ST_CHK: begin
        pj_next = '0;
        if (lpf_rdata == '0) begin
          // prime
          lpf_we     = 1'b1;
          lpf_wdata  = idx;
          tb_we      = 1'b1;
          tb_wdata   = ncpc_pkg::COUNT_W'(idx - VW'(1));
          pr_we      = 1'b1;
          cnt_next   = cnt + (PW+1)'(1);
          lpf_i_next = idx;
          phi_i_next = idx - VW'(1);
        end else begin
          lpf_i_next = lpf_rdata;
          phi_i_next = tb_rdata[VW-1:0];
        end
        state_next = ncpc_pkg::ST_RD_P;
      end
      ncpc_pkg::ST_RD_P: begin
        if (pj >= cnt) begin
          state_next = ncpc_pkg::ST_NEXT;
        end else begin
          state_next = ncpc_pkg::ST_MUL;
        end
      end
      ncpc_pkg::ST_MUL: begin
        p_reg_next = pr_rdata;
        prod_next  = idx * pr_rdata;
        fprod_next = phi_i * fac;
        last_next  = (pr_rdata == lpf_i);
        state_next = ncpc_pkg::ST_WR;
      end
      ncpc_pkg::ST_WR: begin
        if (prod > (2*VW)'(MAX_N)) begin
          state_next = ncpc_pkg::ST_NEXT;
        end else begin
          lpf_we    = 1'b1;
          lpf_waddr = prod[VW-1:0];
          lpf_wdata = p_reg;
          tb_we     = 1'b1;
          tb_waddr  = prod[VW-1:0];
          tb_wdata  = ncpc_pkg::COUNT_W'(fprod[VW-1:0]);
          if (last) begin
            state_next = ncpc_pkg::ST_NEXT;
          end else begin
            pj_next    = pj + (PW+1)'(1);
            state_next = ncpc_pkg::ST_RD_P;
          end
        end
      end
      ncpc_pkg::ST_NEXT: begin
        if (idx == LAST) begin
          idx_next   = '0;
          acc_next   = '0;
          state_next = ncpc_pkg::ST_PRE_RD;
        end else begin
          idx_next   = idx + VW'(1);
          state_next = ncpc_pkg::ST_RD_I;
        end
      end
      ncpc_pkg::ST_PRE_RD: begin
        state_next = ncpc_pkg::ST_PRE_WR;
      end
      ncpc_pkg::ST_PRE_WR: begin
        acc_next = acc + term;
        tb_we    = 1'b1;
        tb_wdata = acc + term;
        if (idx == LAST) begin
          state_next = ncpc_pkg::ST_DONE;
        end else begin
          idx_next   = idx + VW'(1);
          state_next = ncpc_pkg::ST_PRE_RD;
        end
      end
      ncpc_pkg::ST_DONE: begin
        ready = 1'b1;
      end
      default: begin
        state_next = ncpc_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/noncoprime_prefix_count.sv */
`timescale 1ns / 1ps
// Answer: a query is answered in the cycle after it is taken (one prefix RAM read).
// Throughput: one query per cycle once the tables are built.
// Reset: busy stays high while the tables are built: the factor map is cleared,
// then the linear sieve runs, then the prefix sweep runs.
// ----------------------------------------------------------------------------
// noncoprime_prefix_count
// Answers S(n) = sum over k=1..n of (k - phi(k)) by a single table lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module noncoprime_prefix_count #(
  parameter int MAX_N = ncpc_pkg::MAX_N_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [ncpc_pkg::QUERY_W-1:0]     query_index,
  output logic                                  done,
  output logic      [ncpc_pkg::COUNT_W-1:0]     pair_count
);

  localparam int VW   = $clog2(MAX_N + 1);
  localparam int PCAP = MAX_N / 2 + 2;
  localparam int PW   = $clog2(PCAP);

  logic                          lpf_we;
  logic [VW-1:0]                 lpf_waddr, lpf_wdata, lpf_raddr, lpf_rdata;
  logic                          pr_we;
  logic [PW-1:0]                 pr_waddr, pr_raddr;
  logic [VW-1:0]                 pr_wdata, pr_rdata;
  logic                          tb_we;
  logic [VW-1:0]                 tb_waddr, tb_raddr, bld_tb_raddr;
  logic [ncpc_pkg::COUNT_W-1:0]  tb_wdata, tb_rdata;
  logic                          ready;
  logic                          take;
  logic [31:0]                   q_wide;
  logic [VW-1:0]                 q_addr;

  ncpc_builder #(
    .MAX_N(MAX_N),
    .VW   (VW),
    .PCAP (PCAP),
    .PW   (PW)
  ) u_builder (
    .clk      (clk),
    .rst      (rst),
    .lpf_we   (lpf_we),
    .lpf_waddr(lpf_waddr),
    .lpf_wdata(lpf_wdata),
    .lpf_raddr(lpf_raddr),
    .lpf_rdata(lpf_rdata),
    .pr_we    (pr_we),
    .pr_waddr (pr_waddr),
    .pr_wdata (pr_wdata),
    .pr_raddr (pr_raddr),
    .pr_rdata (pr_rdata),
    .tb_we    (tb_we),
    .tb_waddr (tb_waddr),
    .tb_wdata (tb_wdata),
    .tb_raddr (bld_tb_raddr),
    .tb_rdata (tb_rdata),
    .ready    (ready)
  );

  ncpc_ram #(.WIDTH(VW), .DEPTH(MAX_N + 1), .AW(VW)) u_lpf_ram (
    .clk(clk), .we(lpf_we), .waddr(lpf_waddr), .wdata(lpf_wdata),
    .raddr(lpf_raddr), .rdata(lpf_rdata)
  );

  ncpc_ram #(.WIDTH(VW), .DEPTH(PCAP), .AW(PW)) u_prime_ram (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
    .raddr(pr_raddr), .rdata(pr_rdata)
  );

  ncpc_ram #(.WIDTH(ncpc_pkg::COUNT_W), .DEPTH(MAX_N + 1), .AW(VW)) u_table_ram (
    .clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
    .raddr(tb_raddr), .rdata(tb_rdata)
  );

  assign busy   = !ready;
  assign take   = start && ready;
  // queries above the limit saturate
  assign q_wide = 32'(query_index);
  assign q_addr = (q_wide > 32'(MAX_N)) ? VW'(MAX_N) : q_wide[VW-1:0];
  assign tb_raddr = ready ? q_addr : bld_tb_raddr;
  assign pair_count = tb_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= take;
    end
  end

endmodule

`default_nettype wire

/* sv/ncpc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncpc_checker
// Port-level checks for noncoprime_prefix_count, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ncpc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // once built, the tables stay ready until the next reset
  a_ready_sticky: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !busy) else $error("busy rose after build");

  a_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done) else $error("query not answered");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done) else $error("result without query");

  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while building");

endmodule

bind noncoprime_prefix_count ncpc_checker u_ncpc_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);

`default_nettype wire
